>>> src/svg_pkg.sv
// Shared constants, types and arithmetic helpers of the state vector gate engine.
package svg_pkg;

   // Sizes of the store and the number format.
   localparam int MAX_QUBITS = 10;
   localparam int MAX_SHOTS = 4;
   localparam int FRAC_BITS = 14;
   localparam int SHOT_BITS = $clog2(MAX_SHOTS);
   localparam int ADDR_W = SHOT_BITS + MAX_QUBITS;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int DIM_W = MAX_QUBITS + 1;
   localparam int QCOUNT_W = 4;
   localparam int SCOUNT_W = 3;
   localparam int AMP_W = 16;
   localparam int PROD_W = 2 * AMP_W;
   localparam int RND_W = PROD_W + 1 - FRAC_BITS;
   localparam int ACC_W = (RND_W + 4 > AMP_W + 1) ? RND_W + 4 : AMP_W + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int ONE_VAL = (FRAC_BITS >= AMP_W - 1) ? 32767 : (1 << FRAC_BITS);

   // Command codes of the input item.
   localparam logic [2:0] CMD_INIT = 3'd0;
   localparam logic [2:0] CMD_LOAD_COEFF = 3'd1;
   localparam logic [2:0] CMD_APPLY_SINGLE = 3'd2;
   localparam logic [2:0] CMD_APPLY_TWO = 3'd3;
   localparam logic [2:0] CMD_WRITE_AMP = 3'd4;
   localparam logic [2:0] CMD_READ_AMP = 3'd5;

   // Status codes of the result item.
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_QUBIT_RANGE = 2'd1;
   localparam logic [1:0] ST_EQUAL_TARGETS = 2'd2;
   localparam logic [1:0] ST_INDEX_RANGE = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_QUBIT_COUNT = 1'b0;
   localparam logic CSR_SHOT_COUNT = 1'b1;

   typedef enum logic [2:0] {
      OP_NOP, OP_INIT, OP_COEF, OP_GATE1, OP_GATE2, OP_WRITE, OP_READ
   } op_kind_type;

   // One classified item as it travels from the front to the back.
   typedef struct packed {
      op_kind_type               kind;
      logic [1:0]                status;
      logic [QCOUNT_W-1:0]       nq;
      logic [SCOUNT_W-1:0]       ns;
      logic [MAX_QUBITS-1:0]     mask0;
      logic [MAX_QUBITS-1:0]     mask1;
      logic [ADDR_W-1:0]         addr;
      logic [3:0]                coeff_index;
      logic signed [AMP_W-1:0]   value_re;
      logic signed [AMP_W-1:0]   value_im;
   } op_type;

   // Queue state seen by the top level.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Round a product to FRAC_BITS fraction bits, ties toward plus infinity.
   function automatic logic signed [RND_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] t;
      t = (PROD_W + 1)'(p) + ((PROD_W + 1)'(1) <<< (FRAC_BITS - 1));
      return RND_W'(t >>> FRAC_BITS);
   endfunction

   // Saturate an accumulated sum to the amplitude range.
   function automatic logic signed [AMP_W-1:0] sat_amp(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] hi_lim;
      logic signed [ACC_W-1:0] lo_lim;
      hi_lim = ACC_W'(32767);
      lo_lim = ACC_W'(-32768);
      if (a > hi_lim) begin
         return 16'sh7fff;
      end else if (a < lo_lim) begin
         return 16'sh8000;
      end
      return AMP_W'(a);
   endfunction

endpackage

>>> src/svg_ram.sv
// Generic single-port RAM with registered read data.
module svg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write or one read each cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/svg_queue.sv
// Short queue of classified items between the front and the back.
module svg_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  svg_pkg::op_type           push_op,
   input  logic                      pop,
   output svg_pkg::op_type           head_op,
   output svg_pkg::queue_status_type qstat
);

   localparam int PTR_W = $clog2(svg_pkg::QUEUE_DEPTH);

   svg_pkg::op_type    entry_ff [svg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W:0]     count_ff;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (PTR_W + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (PTR_W + 1)'(1);
         end
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head_op = entry_ff[rd_ptr_ff];
   assign qstat.full = (count_ff == (PTR_W + 1)'(svg_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push) else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop) else $error("pop from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W + 1)'(svg_pkg::QUEUE_DEPTH)) else $error("queue count overrun");

endmodule

>>> src/svg_front.sv
// Front end: configuration registers, range checks and item classification.
module svg_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [3:0]                          csr_write_data,
   input  logic [2:0]                          command,
   input  logic [4:0]                          target_a,
   input  logic [4:0]                          target_b,
   input  logic [3:0]                          coeff_index,
   input  logic [1:0]                          shot_select,
   input  logic [9:0]                          basis_index,
   input  logic signed [svg_pkg::AMP_W-1:0]    value_re,
   input  logic signed [svg_pkg::AMP_W-1:0]    value_im,
   output svg_pkg::op_type                     op
);

   logic [svg_pkg::QCOUNT_W-1:0] qubit_count_ff;
   logic [svg_pkg::SCOUNT_W-1:0] shot_count_ff;
   logic [svg_pkg::QCOUNT_W-1:0] nq;
   logic [svg_pkg::SCOUNT_W-1:0] ns;
   logic [4:0]                   lo_t;
   logic [4:0]                   hi_t;
   logic                         addr_bad;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         qubit_count_ff <= svg_pkg::QCOUNT_W'(1);
         shot_count_ff <= svg_pkg::SCOUNT_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            svg_pkg::CSR_QUBIT_COUNT: begin
               qubit_count_ff <= csr_write_data;
            end
            svg_pkg::CSR_SHOT_COUNT: begin
               shot_count_ff <= csr_write_data[svg_pkg::SCOUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective counts, clamped into their legal ranges.
   always_comb begin
      if (qubit_count_ff == '0) begin
         nq = svg_pkg::QCOUNT_W'(1);
      end else if (qubit_count_ff > svg_pkg::QCOUNT_W'(svg_pkg::MAX_QUBITS)) begin
         nq = svg_pkg::QCOUNT_W'(svg_pkg::MAX_QUBITS);
      end else begin
         nq = qubit_count_ff;
      end
      if (shot_count_ff == '0) begin
         ns = svg_pkg::SCOUNT_W'(1);
      end else if (shot_count_ff > svg_pkg::SCOUNT_W'(svg_pkg::MAX_SHOTS)) begin
         ns = svg_pkg::SCOUNT_W'(svg_pkg::MAX_SHOTS);
      end else begin
         ns = shot_count_ff;
      end
   end

   // Classify the item and work out its status.
   always_comb begin
      lo_t = (target_a < target_b) ? target_a : target_b;
      hi_t = (target_a < target_b) ? target_b : target_a;
      addr_bad = ({1'b0, shot_select} >= ns) || ((11'(basis_index) >> nq) != '0);
      op.nq = nq;
      op.ns = ns;
      op.mask0 = '0;
      op.mask1 = '0;
      op.addr = {shot_select[svg_pkg::SHOT_BITS-1:0],
                 basis_index[svg_pkg::MAX_QUBITS-1:0]};
      op.coeff_index = coeff_index;
      op.value_re = value_re;
      op.value_im = value_im;
      op.status = svg_pkg::ST_OK;
      op.kind = svg_pkg::OP_NOP;
      case (command)
         svg_pkg::CMD_INIT: begin
            op.kind = svg_pkg::OP_INIT;
         end
         svg_pkg::CMD_LOAD_COEFF: begin
            op.kind = svg_pkg::OP_COEF;
         end
         svg_pkg::CMD_APPLY_SINGLE: begin
            op.mask0 = svg_pkg::MAX_QUBITS'(1) << target_a;
            if (target_a >= {1'b0, nq}) begin
               op.status = svg_pkg::ST_QUBIT_RANGE;
            end else begin
               op.kind = svg_pkg::OP_GATE1;
            end
         end
         svg_pkg::CMD_APPLY_TWO: begin
            op.mask0 = svg_pkg::MAX_QUBITS'(1) << lo_t;
            op.mask1 = svg_pkg::MAX_QUBITS'(1) << hi_t;
            if (target_a == target_b) begin
               op.status = svg_pkg::ST_EQUAL_TARGETS;
            end else if (hi_t >= {1'b0, nq}) begin
               op.status = svg_pkg::ST_QUBIT_RANGE;
            end else begin
               op.kind = svg_pkg::OP_GATE2;
            end
         end
         svg_pkg::CMD_WRITE_AMP: begin
            if (addr_bad) begin
               op.status = svg_pkg::ST_INDEX_RANGE;
            end else begin
               op.kind = svg_pkg::OP_WRITE;
            end
         end
         svg_pkg::CMD_READ_AMP: begin
            if (addr_bad) begin
               op.status = svg_pkg::ST_INDEX_RANGE;
            end else begin
               op.kind = svg_pkg::OP_READ;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> src/svg_back.sv
// Back end: store sequencer, complex multiply-accumulate unit and result register.
module svg_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              queue_empty,
   input  svg_pkg::op_type                   head_op,
   output logic                              pop,
   output logic                              reset_clearing,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [svg_pkg::AMP_W-1:0]  rsp_amp_re,
   output logic signed [svg_pkg::AMP_W-1:0]  rsp_amp_im
);

   localparam int AW = svg_pkg::ADDR_W;
   localparam int MQ = svg_pkg::MAX_QUBITS;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_SCAN, S_LOAD, S_CAP, S_MUL, S_ACC, S_WB
   } state_type;

   state_type                          state_ff;
   svg_pkg::op_type                    op_ff;
   logic [AW-1:0]                      clr_addr_ff;
   logic [svg_pkg::SCOUNT_W-1:0]       clr_shots_ff;
   logic                               clr_rsp_ff;
   logic [svg_pkg::SCOUNT_W-1:0]       shot_ff;
   logic [svg_pkg::DIM_W-1:0]          loc_ff;
   logic [1:0]                         r_ff;
   logic [1:0]                         c_ff;
   logic signed [svg_pkg::AMP_W-1:0]   vr_ff [4];
   logic signed [svg_pkg::AMP_W-1:0]   vi_ff [4];
   logic signed [svg_pkg::AMP_W-1:0]   cf_re_ff [16];
   logic signed [svg_pkg::AMP_W-1:0]   cf_im_ff [16];
   logic signed [svg_pkg::PROD_W-1:0]  p_rr_ff;
   logic signed [svg_pkg::PROD_W-1:0]  p_ii_ff;
   logic signed [svg_pkg::PROD_W-1:0]  p_ri_ff;
   logic signed [svg_pkg::PROD_W-1:0]  p_ir_ff;
   logic signed [svg_pkg::ACC_W-1:0]   acc_re_ff;
   logic signed [svg_pkg::ACC_W-1:0]   acc_im_ff;
   logic                               rsp_valid_ff;
   logic [1:0]                         rsp_status_ff;
   logic signed [svg_pkg::AMP_W-1:0]   rsp_re_ff;
   logic signed [svg_pkg::AMP_W-1:0]   rsp_im_ff;

   logic                               ram_we;
   logic [AW-1:0]                      ram_addr;
   logic [2*svg_pkg::AMP_W-1:0]        ram_wdata;
   logic [2*svg_pkg::AMP_W-1:0]        ram_rdata;
   logic [svg_pkg::DIM_W-1:0]          dim;
   logic                               quad;
   logic [1:0]                         last_sub;
   logic [3:0]                         k;
   logic [1:0]                         sub;
   logic [MQ-1:0]                      loc_sub;
   logic                               clr_one;
   logic signed [svg_pkg::AMP_W-1:0]   wb_re;
   logic signed [svg_pkg::AMP_W-1:0]   wb_im;

   // Shape of the current gate: pair or quad, and the coefficient index.
   assign quad = (op_ff.kind == svg_pkg::OP_GATE2);
   assign last_sub = quad ? 2'd3 : 2'd1;
   assign k = quad ? {r_ff, c_ff} : {2'b00, r_ff[0], c_ff[0]};
   assign dim = svg_pkg::DIM_W'(1) << op_ff.nq;
   assign pop = (state_ff == S_IDLE) && !queue_empty;

   // Address of one member of the current block, clear data and saturated write-back values.
   always_comb begin
      sub = (state_ff == S_WB) ? r_ff : c_ff;
      loc_sub = loc_ff[MQ-1:0] | (sub[0] ? op_ff.mask0 : '0) | (sub[1] ? op_ff.mask1 : '0);
      clr_one = (clr_addr_ff[MQ-1:0] == '0) &&
                ({1'b0, clr_addr_ff[AW-1:MQ]} < clr_shots_ff);
      wb_re = svg_pkg::sat_amp(acc_re_ff);
      wb_im = svg_pkg::sat_amp(acc_im_ff);
   end

   // Store port control.
   always_comb begin
      ram_we = 1'b0;
      ram_addr = {shot_ff[svg_pkg::SHOT_BITS-1:0], loc_sub};
      ram_wdata = {wb_re, wb_im};
      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = clr_addr_ff;
            ram_wdata = clr_one ? {svg_pkg::AMP_W'(svg_pkg::ONE_VAL), svg_pkg::AMP_W'(0)}
                                : '0;
         end
         S_IDLE: begin
            ram_we = pop && (head_op.kind == svg_pkg::OP_WRITE);
            ram_addr = head_op.addr;
            ram_wdata = {head_op.value_re, head_op.value_im};
         end
         S_WB: begin
            ram_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   svg_ram #(
      .WIDTH(2 * svg_pkg::AMP_W),
      .DEPTH(svg_pkg::STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .we(ram_we),
      .addr(ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // Sequencer, datapath registers and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_addr_ff <= '0;
         clr_shots_ff <= svg_pkg::SCOUNT_W'(1);
         clr_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            cf_re_ff[i] <= '0;
            cf_im_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == '1) begin
                  state_ff <= S_IDLE;
                  if (clr_rsp_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_status_ff <= svg_pkg::ST_OK;
                     rsp_re_ff <= '0;
                     rsp_im_ff <= '0;
                  end
               end
            end
            S_IDLE: begin
               if (pop) begin
                  op_ff <= head_op;
                  rsp_status_ff <= head_op.status;
                  rsp_re_ff <= '0;
                  rsp_im_ff <= '0;
                  shot_ff <= '0;
                  loc_ff <= '0;
                  case (head_op.kind)
                     svg_pkg::OP_INIT: begin
                        clr_addr_ff <= '0;
                        clr_shots_ff <= head_op.ns;
                        clr_rsp_ff <= 1'b1;
                        state_ff <= S_CLEAR;
                     end
                     svg_pkg::OP_COEF: begin
                        cf_re_ff[head_op.coeff_index] <= head_op.value_re;
                        cf_im_ff[head_op.coeff_index] <= head_op.value_im;
                        rsp_valid_ff <= 1'b1;
                     end
                     svg_pkg::OP_READ: begin
                        state_ff <= S_READ;
                     end
                     svg_pkg::OP_GATE1, svg_pkg::OP_GATE2: begin
                        state_ff <= S_SCAN;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_READ: begin
               rsp_valid_ff <= 1'b1;
               rsp_re_ff <= ram_rdata[2*svg_pkg::AMP_W-1:svg_pkg::AMP_W];
               rsp_im_ff <= ram_rdata[svg_pkg::AMP_W-1:0];
               state_ff <= S_IDLE;
            end
            S_SCAN: begin
               if (shot_ff == op_ff.ns) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (loc_ff == dim) begin
                  shot_ff <= shot_ff + svg_pkg::SCOUNT_W'(1);
                  loc_ff <= '0;
               end else if ((loc_ff[MQ-1:0] & (op_ff.mask0 | op_ff.mask1)) != '0) begin
                  loc_ff <= loc_ff + svg_pkg::DIM_W'(1);
               end else begin
                  c_ff <= '0;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               state_ff <= S_CAP;
            end
            S_CAP: begin
               vr_ff[c_ff] <= ram_rdata[2*svg_pkg::AMP_W-1:svg_pkg::AMP_W];
               vi_ff[c_ff] <= ram_rdata[svg_pkg::AMP_W-1:0];
               if (c_ff == last_sub) begin
                  c_ff <= '0;
                  r_ff <= '0;
                  acc_re_ff <= '0;
                  acc_im_ff <= '0;
                  state_ff <= S_MUL;
               end else begin
                  c_ff <= c_ff + 2'd1;
                  state_ff <= S_LOAD;
               end
            end
            S_MUL: begin
               p_rr_ff <= cf_re_ff[k] * vr_ff[c_ff];
               p_ii_ff <= cf_im_ff[k] * vi_ff[c_ff];
               p_ri_ff <= cf_re_ff[k] * vi_ff[c_ff];
               p_ir_ff <= cf_im_ff[k] * vr_ff[c_ff];
               state_ff <= S_ACC;
            end
            S_ACC: begin
               acc_re_ff <= acc_re_ff + svg_pkg::ACC_W'(svg_pkg::round_prod(p_rr_ff))
                                      - svg_pkg::ACC_W'(svg_pkg::round_prod(p_ii_ff));
               acc_im_ff <= acc_im_ff + svg_pkg::ACC_W'(svg_pkg::round_prod(p_ri_ff))
                                      + svg_pkg::ACC_W'(svg_pkg::round_prod(p_ir_ff));
               if (c_ff == last_sub) begin
                  state_ff <= S_WB;
               end else begin
                  c_ff <= c_ff + 2'd1;
                  state_ff <= S_MUL;
               end
            end
            S_WB: begin
               acc_re_ff <= '0;
               acc_im_ff <= '0;
               c_ff <= '0;
               if (r_ff == last_sub) begin
                  loc_ff <= loc_ff + svg_pkg::DIM_W'(1);
                  state_ff <= S_SCAN;
               end else begin
                  r_ff <= r_ff + 2'd1;
                  state_ff <= S_MUL;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign reset_clearing = (state_ff == S_CLEAR) && !clr_rsp_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_amp_re = rsp_re_ff;
   assign rsp_amp_im = rsp_im_ff;

   a_cap_after_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CAP) |-> ($past(state_ff) == S_LOAD)) else $error("capture without read");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != svg_pkg::ST_OK) |->
      (rsp_re_ff == '0 && rsp_im_ff == '0)) else $error("error result carries data");
   a_loc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (loc_ff <= dim)) else $error("sweep ran past the vector");

endmodule

>>> src/state_vector_gate_engine_top.sv
// Top level of the state vector gate engine.
//
// Commands arrive on the req_ ports and are taken at a clock edge where start
// is high and busy is low. Each command gives exactly one result on the rsp_
// ports, shown for one cycle with rsp_valid high; the receiver cannot stall,
// so results are never held back. Configuration (qubit and shot counts) is
// written on the csr_ port, one register per cycle; the user must write it
// only while the engine is idle, as the block itself does not enforce this.
// A two-entry queue sits between the command decoder and the executor, so
// busy only rises when both entries wait, or during the clear after reset.
// Init clears the whole 4096-entry store. A gate sweeps every active shot:
// per shot it skips each index that has a target bit set, and for each pair
// (single) or quad (two-qubit) it reads the members through the single store
// port, then for each output multiplies and accumulates in the shared complex
// multiply-accumulate unit and writes the saturated result back.
// After reset the store is cleared in a pass over all 4096 entries with busy
// high; then basis 0 of shot 0 holds one, coefficients are zero and both
// counts are one.
module state_vector_gate_engine_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_command,
   input  logic [4:0]                         req_target_a,
   input  logic [4:0]                         req_target_b,
   input  logic [3:0]                         req_coeff_index,
   input  logic [1:0]                         req_shot_select,
   input  logic [9:0]                         req_basis_index,
   input  logic signed [svg_pkg::AMP_W-1:0]   req_value_re,
   input  logic signed [svg_pkg::AMP_W-1:0]   req_value_im,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic signed [svg_pkg::AMP_W-1:0]   rsp_amp_re,
   output logic signed [svg_pkg::AMP_W-1:0]   rsp_amp_im,
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [3:0]                         csr_write_data
);

   svg_pkg::op_type            front_op;
   svg_pkg::op_type            head_op;
   svg_pkg::queue_status_type  qstat;
   logic                       accept;
   logic                       pop;
   logic                       reset_clearing;

   // An item is taken whenever the queue has room and the reset clear is done.
   assign busy = qstat.full || reset_clearing;
   assign accept = start && !busy;

   svg_front u_front (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .command(req_command),
      .target_a(req_target_a),
      .target_b(req_target_b),
      .coeff_index(req_coeff_index),
      .shot_select(req_shot_select),
      .basis_index(req_basis_index),
      .value_re(req_value_re),
      .value_im(req_value_im),
      .op(front_op)
   );

   svg_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(accept),
      .push_op(front_op),
      .pop(pop),
      .head_op(head_op),
      .qstat(qstat)
   );

   svg_back u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(qstat.empty),
      .head_op(head_op),
      .pop(pop),
      .reset_clearing(reset_clearing),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_amp_re(rsp_amp_re),
      .rsp_amp_im(rsp_amp_im)
   );

endmodule
